### rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command codes, configuration register indexes, field widths and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int INDEX_W   = 11;
	localparam int WORD_W    = 16;
	localparam int OUT_COL_W = 7;
	localparam int OUT_ROW_W = 5;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;
	localparam logic [COLOR_W-1:0] FORE_RESET = 4'd7;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT     = 2'd0,
		CMD_NEWLINE = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BACK = 1'b0,
		CFG_FORE = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_COPY  = 4'b0100,
		ST_SWEEP = 4'b1000
	} state_t;

endpackage
`default_nettype wire

### rtl/text_console_writer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_core: text-mode screen store with a write cursor
// Holds ROWS x COLUMNS cells (attribute byte high, character byte low) in
// one synchronous memory and executes put char, new line, clear and read.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on cell_word, cursor_col and cursor_row for one cycle with done, and
// the receiver must take it in that cycle, since it cannot stall the block.
// Put char and new line that do not scroll leave busy low and report in the
// next cycle, so they can follow back to back; read cell raises busy for its
// read state, which loads the registered read data of the store into cell_word
// with done. The screen store has a single write port, so a scroll copies the
// store one cell per cycle, waits for the last copy write and then blanks the
// last row; clear writes every cell once. Both report in the same cycle that
// busy falls. After reset a clearing pass runs with busy high. Configuration
// writes are always taken.
module text_console_writer_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire  [tcw_pkg::CMD_W-1:0]          cmd,
	input  wire  [tcw_pkg::CHAR_W-1:0]         char_code,
	input  wire  [tcw_pkg::INDEX_W-1:0]        cell_index,
	output logic                               done,
	output logic [tcw_pkg::WORD_W-1:0]         cell_word,
	output logic [tcw_pkg::OUT_COL_W-1:0]      cursor_col,
	output logic [tcw_pkg::OUT_ROW_W-1:0]      cursor_row,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [tcw_pkg::COLOR_W-1:0]        cfg_data
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);

	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

	tcw_pkg::state_t state_q;
	tcw_pkg::cmd_t   cmd_in;

	logic [tcw_pkg::WORD_W-1:0]  mem_q [CELLS];
	logic [tcw_pkg::WORD_W-1:0]  rd_data_q;
	logic [tcw_pkg::WORD_W-1:0]  cell_word_q;
	logic [tcw_pkg::WORD_W-1:0]  wr_data;
	logic [ADDR_W-1:0]           wr_addr;
	logic [ADDR_W-1:0]           rd_addr;
	logic [ADDR_W-1:0]           put_addr;
	logic [ADDR_W-1:0]           ptr_q;
	logic [ADDR_W-1:0]           ptr_s1;
	logic [ADDR_W-1:0]           row_base_q;
	logic [COL_W-1:0]            col_q;
	logic [ROW_W-1:0]            row_q;
	logic [tcw_pkg::COLOR_W-1:0] back_q;
	logic [tcw_pkg::COLOR_W-1:0] fore_q;
	logic                        wr_en;
	logic                        copy_vld_s1;
	logic                        report_q;
	logic                        in_range_q;
	logic                        done_q;
	logic                        accept;

	assign cmd_in     = tcw_pkg::cmd_t'(cmd);
	assign busy       = (state_q != tcw_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign cell_word  = cell_word_q;
	assign cursor_col = tcw_pkg::OUT_COL_W'(col_q);
	assign cursor_row = tcw_pkg::OUT_ROW_W'(row_q);
	assign put_addr   = row_base_q + ADDR_W'(col_q);

	// A pending copy write owns the write port; the sweep waits for it.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = put_addr;
		wr_data = {back_q, fore_q, char_code};
		if (copy_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = ptr_s1;
			wr_data = rd_data_q;
		end else if (state_q == tcw_pkg::ST_SWEEP) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q;
			wr_data = '0;
		end else if (accept && cmd_in == tcw_pkg::CMD_PUT) begin
			wr_en   = 1'b1;
		end
	end

	always_comb begin
		if (state_q == tcw_pkg::ST_COPY) begin
			rd_addr = ptr_q + ROW_STEP;
		end else begin
			rd_addr = ADDR_W'(cell_index);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
		ptr_s1    <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_SWEEP;
			ptr_q       <= '0;
			report_q    <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			row_base_q  <= '0;
			done_q      <= 1'b0;
			copy_vld_s1 <= 1'b0;
			in_range_q  <= 1'b0;
			cell_word_q <= '0;
			back_q      <= tcw_pkg::BACK_RESET;
			fore_q      <= tcw_pkg::FORE_RESET;
		end else begin
			done_q      <= 1'b0;
			copy_vld_s1 <= (state_q == tcw_pkg::ST_COPY);

			if (cfg_valid && cfg_ready) begin
				case (tcw_pkg::cfg_idx_t'(cfg_index))
					tcw_pkg::CFG_BACK: back_q <= cfg_data;
					tcw_pkg::CFG_FORE: fore_q <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				tcw_pkg::ST_IDLE: begin
					if (start) begin
						cell_word_q <= '0;
						case (cmd_in)
							tcw_pkg::CMD_PUT, tcw_pkg::CMD_NEWLINE: begin
								if (cmd_in == tcw_pkg::CMD_PUT && col_q != COL_LAST) begin
									col_q  <= col_q + 1'b1;
									done_q <= 1'b1;
								end else begin
									col_q <= '0;
									if (row_q == ROW_LAST) begin
										// The row stays on the last line while the store scrolls.
										state_q  <= tcw_pkg::ST_COPY;
										ptr_q    <= '0;
										report_q <= 1'b1;
									end else begin
										row_q      <= row_q + 1'b1;
										row_base_q <= row_base_q + ROW_STEP;
										done_q     <= 1'b1;
									end
								end
							end
							tcw_pkg::CMD_CLEAR: begin
								col_q      <= '0;
								row_q      <= '0;
								row_base_q <= '0;
								ptr_q      <= '0;
								report_q   <= 1'b1;
								state_q    <= tcw_pkg::ST_SWEEP;
							end
							tcw_pkg::CMD_READ: begin
								in_range_q <= (32'(cell_index) < CELLS);
								state_q    <= tcw_pkg::ST_READ;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				tcw_pkg::ST_READ: begin
					cell_word_q <= in_range_q ? rd_data_q : '0;
					done_q      <= 1'b1;
					state_q     <= tcw_pkg::ST_IDLE;
				end
				tcw_pkg::ST_COPY: begin
					// The pointer runs on into the last row, where the sweep starts.
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == CELL_LAST - ROW_STEP) begin
						state_q <= tcw_pkg::ST_SWEEP;
					end
				end
				tcw_pkg::ST_SWEEP: begin
					if (!copy_vld_s1) begin
						if (ptr_q == CELL_LAST) begin
							state_q <= tcw_pkg::ST_IDLE;
							done_q  <= report_q;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				default: state_q <= tcw_pkg::ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_idle_no_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_IDLE) |-> !copy_vld_s1)
		else $error("copy write pending while idle");

	a_read_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_in == tcw_pkg::CMD_READ) |=> ##1 done_q)
		else $error("read cell did not report two cycles after acceptance");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_LAST)
		else $error("cursor row beyond the last row");
`endif

endmodule
`default_nettype wire

### test/text_console_writer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core_tb: self-checking bench for the text console writer
// Issues put char, new line, clear and read cell commands. It starts with a
// short table of probes and then runs phases of random traffic with different
// color settings. A behavioral copy of the screen and cursor predicts each
// result; a monitor checks every result transaction against it or the table.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;

	localparam int COLS = 80;
	localparam int LINES = 25;
	localparam int CELLS = COLS * LINES;
	localparam int ITEM_TARGET = 1150;
	localparam int PHASE_LEN = 113;
	// A scroll or a clear keeps the block busy while it walks the whole screen.
	localparam longint CYCLE_LIMIT = 10000000;

	typedef struct packed {
		logic [tcw_pkg::WORD_W-1:0]    cell_word;
		logic [tcw_pkg::OUT_COL_W-1:0] cursor_col;
		logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row;
	} console_result_t;

	typedef struct packed {
		tcw_pkg::cmd_t               op;
		logic [tcw_pkg::CHAR_W-1:0]  ch;
		logic [tcw_pkg::INDEX_W-1:0] idx;
		bit                          typed;
		console_result_t             want;
	} probe_row_t;

	// Rows marked typed carry their result; the rest rely on the predictor.
	localparam int N_PROBES = 23;
	localparam probe_row_t PROBES [N_PROBES] = '{
		'{tcw_pkg::CMD_READ,    8'h00, 11'd0,    1'b1, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd1999, 1'b1, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'hFF, 11'd2000, 1'b1, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'hFF, 11'd2047, 1'b1, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_PUT,     8'hFF, 11'd2047, 1'b1, '{16'h0000, 7'd1, 5'd0}},
		'{tcw_pkg::CMD_PUT,     8'h00, 11'd0,    1'b1, '{16'h0000, 7'd2, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd0,    1'b1, '{16'h07FF, 7'd2, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd1,    1'b1, '{16'h0700, 7'd2, 5'd0}},
		'{tcw_pkg::CMD_NEWLINE, 8'hFF, 11'd2047, 1'b1, '{16'h0000, 7'd0, 5'd1}},
		'{tcw_pkg::CMD_PUT,     8'h55, 11'd0,    1'b1, '{16'h0000, 7'd1, 5'd1}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd80,   1'b1, '{16'h0755, 7'd1, 5'd1}},
		'{tcw_pkg::CMD_PUT,     8'hAA, 11'd1365, 1'b0, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd81,   1'b0, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd2,    1'b0, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_NEWLINE, 8'h00, 11'd0,    1'b0, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_CLEAR,   8'hFF, 11'd2047, 1'b1, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd0,    1'b1, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd81,   1'b1, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_PUT,     8'h80, 11'd0,    1'b0, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_PUT,     8'h7F, 11'd0,    1'b0, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd0,    1'b0, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_READ,    8'h00, 11'd1,    1'b0, '{16'h0000, 7'd0, 5'd0}},
		'{tcw_pkg::CMD_CLEAR,   8'h00, 11'd0,    1'b1, '{16'h0000, 7'd0, 5'd0}}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	tcw_pkg::cmd_t                 cmd = tcw_pkg::CMD_PUT;
	logic [tcw_pkg::CHAR_W-1:0]    char_code = '0;
	logic [tcw_pkg::INDEX_W-1:0]   cell_index = '0;
	logic                          done;
	logic [tcw_pkg::WORD_W-1:0]    cell_word;
	logic [tcw_pkg::OUT_COL_W-1:0] cursor_col;
	logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	tcw_pkg::cfg_idx_t             cfg_index = tcw_pkg::CFG_BACK;
	logic [tcw_pkg::COLOR_W-1:0]   cfg_data = '0;

	// Predicted screen contents, cursor and colors.
	logic [tcw_pkg::WORD_W-1:0]    screen_copy [CELLS];
	int                            cur_col;
	int                            cur_row;
	logic [tcw_pkg::COLOR_W-1:0]   back_nib = tcw_pkg::BACK_RESET;
	logic [tcw_pkg::COLOR_W-1:0]   fore_nib = tcw_pkg::FORE_RESET;

	console_result_t               pending_q [$];
	int                            errors = 0;
	int                            items = 0;
	bit                            idle_en = 1'b1;
	longint                        cycles = 0;

	text_console_writer_core #(
		.COLUMNS(COLS),
		.ROWS(LINES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.char_code(char_code),
		.cell_index(cell_index),
		.done(done),
		.cell_word(cell_word),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void wipe_screen();
		for (int i = 0; i < CELLS; i++)
			screen_copy[i] = '0;
		cur_col = 0;
		cur_row = 0;
	endfunction

	function automatic void advance_line();
		cur_col = 0;
		cur_row++;
		if (cur_row >= LINES) begin
			for (int i = 0; i < CELLS - COLS; i++)
				screen_copy[i] = screen_copy[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen_copy[i] = '0;
			cur_row = LINES - 1;
		end
	endfunction

	function automatic console_result_t console_predict(tcw_pkg::cmd_t op,
			logic [tcw_pkg::CHAR_W-1:0] ch, logic [tcw_pkg::INDEX_W-1:0] idx);
		console_result_t r;
		r.cell_word = '0;
		case (op)
			tcw_pkg::CMD_PUT: begin
				screen_copy[cur_row * COLS + cur_col] = {back_nib, fore_nib, ch};
				cur_col++;
				if (cur_col >= COLS)
					advance_line();
			end
			tcw_pkg::CMD_NEWLINE: advance_line();
			tcw_pkg::CMD_CLEAR: wipe_screen();
			default: begin
				if (idx < CELLS)
					r.cell_word = screen_copy[idx];
			end
		endcase
		r.cursor_col = cur_col[tcw_pkg::OUT_COL_W-1:0];
		r.cursor_row = cur_row[tcw_pkg::OUT_ROW_W-1:0];
		return r;
	endfunction

	// Near the bottom row puts dominate so that lines wrap into scrolls.
	function automatic tcw_pkg::cmd_t pick_cmd(bit deep);
		int r;
		r = $urandom_range(0, 99);
		if (deep) begin
			if (r < 75)
				return tcw_pkg::CMD_PUT;
			else if (r < 81)
				return tcw_pkg::CMD_NEWLINE;
			return tcw_pkg::CMD_READ;
		end
		if (r < 55)
			return tcw_pkg::CMD_PUT;
		else if (r < 65)
			return tcw_pkg::CMD_NEWLINE;
		else if (r < 67)
			return tcw_pkg::CMD_CLEAR;
		return tcw_pkg::CMD_READ;
	endfunction

	function automatic logic [tcw_pkg::CHAR_W-1:0] pick_char();
		return tcw_pkg::CHAR_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [tcw_pkg::INDEX_W-1:0] pick_any_cell();
		return tcw_pkg::INDEX_W'($urandom_range(0, 2 ** tcw_pkg::INDEX_W - 1));
	endfunction

	// Most reads land on the current or previous line, where text was written.
	function automatic logic [tcw_pkg::INDEX_W-1:0] pick_cell();
		int r;
		int base_row;
		r = $urandom_range(0, 99);
		if (r < 35)
			return pick_any_cell();
		if (r < 42)
			return tcw_pkg::INDEX_W'($urandom_range(CELLS, 2 ** tcw_pkg::INDEX_W - 1));
		base_row = (cur_row > 0 && r[0]) ? cur_row - 1 : cur_row;
		return tcw_pkg::INDEX_W'(base_row * COLS + $urandom_range(0, COLS - 1));
	endfunction

	task automatic issue(input tcw_pkg::cmd_t op, input logic [tcw_pkg::CHAR_W-1:0] ch,
			input logic [tcw_pkg::INDEX_W-1:0] idx, input bit typed,
			input console_result_t want);
		console_result_t predicted;
		while (idle_en && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		char_code <= ch;
		cell_index <= idx;
		do @(posedge clk); while (busy);
		predicted = console_predict(op, ch, idx);
		pending_q.push_back(typed ? want : predicted);
		items++;
	endtask

	task automatic fill_line();
		int n;
		n = COLS - cur_col;
		repeat (n) issue(tcw_pkg::CMD_PUT, pick_char(), pick_any_cell(), 1'b0, '0);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_color(input tcw_pkg::cfg_idx_t reg_sel,
			input logic [tcw_pkg::COLOR_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_sel;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (reg_sel == tcw_pkg::CFG_BACK)
			back_nib = val;
		else
			fore_nib = val;
	endtask

	initial begin
		int phase;
		int phase_start;
		bit deep;
		wipe_screen();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (PROBES[i])
			issue(PROBES[i].op, PROBES[i].ch, PROBES[i].idx, PROBES[i].typed, PROBES[i].want);

		phase = 0;
		while (items < ITEM_TARGET) begin
			// Colors change only once every outstanding result has come back.
			drain_results();
			case (phase)
				0: begin
					write_color(tcw_pkg::CFG_BACK, 4'hF);
					write_color(tcw_pkg::CFG_FORE, 4'h0);
				end
				1: begin
					write_color(tcw_pkg::CFG_BACK, 4'h0);
					write_color(tcw_pkg::CFG_FORE, 4'hF);
				end
				2: begin
					write_color(tcw_pkg::CFG_FORE, 4'hF);
					write_color(tcw_pkg::CFG_BACK, 4'hF);
				end
				3: begin
					write_color(tcw_pkg::CFG_BACK, 4'h0);
					write_color(tcw_pkg::CFG_FORE, 4'h0);
				end
				default: begin
					write_color(tcw_pkg::CFG_FORE, tcw_pkg::COLOR_W'($urandom_range(0, 15)));
					write_color(tcw_pkg::CFG_BACK, tcw_pkg::COLOR_W'($urandom_range(0, 15)));
				end
			endcase

			deep = (phase % 3 == 1);
			idle_en = (phase != 2);
			phase_start = items;
			if (deep) begin
				while (cur_row != LINES - 1)
					issue(tcw_pkg::CMD_NEWLINE, pick_char(), pick_any_cell(), 1'b0, '0);
				fill_line();
			end else if ($urandom_range(0, 1)) begin
				fill_line();
			end
			while (items - phase_start < PHASE_LEN)
				issue(pick_cmd(deep), pick_char(), pick_cell(), 1'b0, '0);
			phase++;
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		console_result_t exp_r;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$error("result transaction with none expected: cell_word %h col %0d row %0d",
					cell_word, cursor_col, cursor_row);
				errors++;
			end else begin
				exp_r = pending_q.pop_front();
				if (cell_word !== exp_r.cell_word) begin
					$error("cell_word: expected %h, actual %h", exp_r.cell_word, cell_word);
					errors++;
				end
				if (cursor_col !== exp_r.cursor_col) begin
					$error("cursor_col: expected %0d, actual %0d", exp_r.cursor_col, cursor_col);
					errors++;
				end
				if (cursor_row !== exp_r.cursor_row) begin
					$error("cursor_row: expected %0d, actual %0d", exp_r.cursor_row, cursor_row);
					errors++;
				end
			end
		end
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

### filelist.f
rtl/tcw_pkg.sv
rtl/text_console_writer_core.sv
test/text_console_writer_core_tb.sv
